>>> sv/gradient_noise_3d_eval_core_defines.svh
// Assertion macros for the 3D gradient noise evaluation core.
// Expands to concurrent assertions on clk / arst_n unless SYNTH is defined.
`ifndef GRADIENT_NOISE_3D_EVAL_CORE_DEFINES_SVH
`define GRADIENT_NOISE_3D_EVAL_CORE_DEFINES_SVH
`ifndef SYNTH
`define GN3D_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	prop) else $error("gn3d assertion failed");
`define GN3D_ASSERT_RST(lbl, prop) lbl: assert property (@(posedge clk) prop) \
	else $error("gn3d reset assertion failed");
`else
`define GN3D_ASSERT(lbl, prop)
`define GN3D_ASSERT_RST(lbl, prop)
`endif
`endif

>>> sv/gn3d_pkg.sv
// Shared types and constants of the 3D gradient noise evaluation core.
// No dependencies.
package gn3d_pkg;
	localparam int NODES_PER_AXIS = 16;
	localparam int AXIS_W         = 4;
	localparam int POS_FRAC_BITS  = 16;
	localparam int POS_W          = AXIS_W + POS_FRAC_BITS;
	localparam int GRAD_W         = 16;
	localparam int NCORNER        = 8;
	localparam int BANK_AW        = 3 * (AXIS_W - 1);
	localparam int BANK_DEPTH     = 1 << BANK_AW;
	localparam int T_W            = POS_FRAC_BITS + 1;
	localparam int M_W            = POS_FRAC_BITS + 2;
	localparam int OFF_W          = POS_FRAC_BITS + 2;
	localparam int DOT_W          = GRAD_W + 3;
	localparam int TERM_W         = DOT_W + 2;
	localparam int SUM_W          = TERM_W + 3;
	localparam int NOISE_W        = 16;
	localparam int CFG_IDX_W      = 2;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Z = 2'd2;

	typedef logic signed [GRAD_W-1:0] grad_t;

	typedef struct packed {
		grad_t gz;
		grad_t gy;
		grad_t gx;
	} gvec_t;

	localparam int GVEC_W = 3 * GRAD_W;

	// gradient write request into the banked table
	typedef struct packed {
		logic               en;
		logic [2:0]         bank;
		logic [BANK_AW-1:0] addr;
		gvec_t              data;
	} wreq_t;

	// evaluate request as it leaves the table read stage
	typedef struct packed {
		logic                     valid;
		logic                     oor;
		logic [POS_FRAC_BITS-1:0] fz;
		logic [POS_FRAC_BITS-1:0] fy;
		logic [POS_FRAC_BITS-1:0] fx;
	} query_t;
endpackage

>>> sv/gn3d_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module gn3d_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

>>> sv/gn3d_table.sv
// Gradient table split into eight parity banks, one per corner of a cell.
// Depends on gn3d_pkg and gn3d_ram.
module gn3d_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gn3d_pkg::wreq_t              wr,
	input  logic                         re,
	input  logic [gn3d_pkg::AXIS_W-1:0]  cx,
	input  logic [gn3d_pkg::AXIS_W-1:0]  cy,
	input  logic [gn3d_pkg::AXIS_W-1:0]  cz,
	output gn3d_pkg::gvec_t [gn3d_pkg::NCORNER-1:0] corner
);
	import gn3d_pkg::*;

	logic [2:0]  par_q;
	logic [GVEC_W-1:0] rdata [NCORNER];

	// bank b holds nodes whose coordinate parities are b; the node of the
	// cell that falls in bank b is cell or cell+1 on each axis
	for (genvar b = 0; b < NCORNER; b++) begin : g_bank
		localparam logic [2:0] B = 3'(b);
		logic [AXIS_W-1:0]  nx, ny, nz;
		logic [BANK_AW-1:0] raddr;
		assign nx = cx + AXIS_W'(B[0] ^ cx[0]);
		assign ny = cy + AXIS_W'(B[1] ^ cy[0]);
		assign nz = cz + AXIS_W'(B[2] ^ cz[0]);
		assign raddr = {nz[AXIS_W-1:1], ny[AXIS_W-1:1], nx[AXIS_W-1:1]};
		gn3d_ram #(.WIDTH(GVEC_W), .DEPTH(BANK_DEPTH)) u_ram (
			.clk   (clk),
			.we    (wr.en && (wr.bank == B)),
			.waddr (wr.addr),
			.wdata (wr.data),
			.re    (re),
			.raddr (raddr),
			.rdata (rdata[b])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			par_q <= '0;
		end else if (re) begin
			par_q <= {cz[0], cy[0], cx[0]};
		end
	end

	// rotate bank outputs into corner order
	always_comb begin
		for (int c = 0; c < NCORNER; c++) begin
			corner[c] = gvec_t'(rdata[3'(c) ^ par_q]);
		end
	end
endmodule

>>> sv/gn3d_datapath.sv
// Corner dot products, smoothstep weights and the final sum, stages s2..s6.
// Depends on gn3d_pkg.
module gn3d_datapath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   adv,
	input  gn3d_pkg::query_t                       q_s1,
	input  gn3d_pkg::gvec_t [gn3d_pkg::NCORNER-1:0] corner,
	output logic                                   valid_s6,
	output logic                                   oor_s6,
	output logic [gn3d_pkg::NOISE_W-1:0]           noise_s6
);
	import gn3d_pkg::*;

	localparam int F = POS_FRAC_BITS;
	localparam logic [2*T_W:0] HALF_U = (2*T_W+1)'(1) << (F - 1);

	logic                  v_s2, v_s3, v_s4, v_s5;
	logic                  oor_s2, oor_s3, oor_s4, oor_s5;
	logic [T_W-1:0]        qv_s2 [3][2];
	logic [M_W-1:0]        m_s2  [3][2];
	logic [T_W-1:0]        s_s3  [3][2];
	logic [T_W-1:0]        wxy_s4 [4];
	logic [T_W-1:0]        sz_s4 [2];
	logic [T_W-1:0]        wt_s5 [NCORNER];
	logic signed [DOT_W-1:0]  dot_s2 [NCORNER];
	logic signed [DOT_W-1:0]  dot_s3 [NCORNER];
	logic signed [DOT_W-1:0]  dot_s4 [NCORNER];
	logic signed [DOT_W-1:0]  dot_s5 [NCORNER];
	logic signed [TERM_W-1:0] term_s6 [NCORNER];

	logic [T_W-1:0]          qv_d [3][2];
	logic [M_W-1:0]          m_d  [3][2];
	logic signed [DOT_W-1:0] dot_d [NCORNER];
	logic [T_W-1:0]          s_d  [3][2];
	logic [T_W-1:0]          wxy_d [4];
	logic [T_W-1:0]          wt_d [NCORNER];
	logic signed [TERM_W-1:0] term_d [NCORNER];

	// s1: squares of t and the 3 - 2t factor; offset dot gradient
	always_comb begin
		logic [F-1:0]             f [3];
		logic [T_W-1:0]           t;
		logic [2*T_W-1:0]         tt;
		logic signed [OFF_W-1:0]  off [3][2];
		logic signed [OFF_W+GRAD_W+1:0] acc;
		grad_t                    g [3];
		f[0] = q_s1.fx;
		f[1] = q_s1.fy;
		f[2] = q_s1.fz;
		for (int k = 0; k < 3; k++) begin
			off[k][0] = $signed({2'b00, f[k]});
			off[k][1] = $signed({2'b00, f[k]}) - $signed(OFF_W'(1) << F);
			for (int sd = 0; sd < 2; sd++) begin
				t = (sd == 0) ? (T_W'(1) << F) - T_W'(f[k]) : T_W'(f[k]);
				tt = t * t;
				qv_d[k][sd] = T_W'(((2*T_W+1)'(tt) + HALF_U) >> F);
				m_d[k][sd] = M_W'(3 * (M_W'(1) << F)) - {t, 1'b0};
			end
		end
		for (int c = 0; c < NCORNER; c++) begin
			g[0] = corner[c].gx;
			g[1] = corner[c].gy;
			g[2] = corner[c].gz;
			acc = '0;
			for (int k = 0; k < 3; k++) begin
				acc = acc + (OFF_W+GRAD_W+2)'(off[k][(c >> k) & 1] * g[k]);
			end
			acc = acc + (OFF_W+GRAD_W+2)'(1 << (F - 1));
			dot_d[c] = DOT_W'(acc >>> F);
		end
	end

	// s2: finish smoothstep
	always_comb begin
		logic [T_W+M_W:0] p;
		for (int k = 0; k < 3; k++) begin
			for (int sd = 0; sd < 2; sd++) begin
				p = (T_W+M_W+1)'(qv_s2[k][sd] * m_s2[k][sd]) + (T_W+M_W+1)'(1 << (F - 1));
				s_d[k][sd] = T_W'(p >> F);
			end
		end
	end

	// s3: x by y weights; s4: times z weight
	always_comb begin
		logic [2*T_W:0] p;
		for (int i = 0; i < 4; i++) begin
			p = (2*T_W+1)'(s_s3[0][i & 1] * s_s3[1][(i >> 1) & 1]) + HALF_U;
			wxy_d[i] = T_W'(p >> F);
		end
		for (int c = 0; c < NCORNER; c++) begin
			p = (2*T_W+1)'(wxy_s4[c & 3] * sz_s4[(c >> 2) & 1]) + HALF_U;
			wt_d[c] = T_W'(p >> F);
		end
	end

	// s5: weighted term per corner
	always_comb begin
		logic signed [T_W+DOT_W+1:0] p;
		for (int c = 0; c < NCORNER; c++) begin
			p = (T_W+DOT_W+2)'($signed({1'b0, wt_s5[c]}) * dot_s5[c])
				+ (T_W+DOT_W+2)'(1 << (F - 1));
			term_d[c] = TERM_W'(p >>> F);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qv_s2 <= qv_d;
			m_s2 <= m_d;
			dot_s2 <= dot_d;
			s_s3 <= s_d;
			dot_s3 <= dot_s2;
			wxy_s4 <= wxy_d;
			sz_s4 <= s_s3[2];
			dot_s4 <= dot_s3;
			wt_s5 <= wt_d;
			dot_s5 <= dot_s4;
			term_s6 <= term_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s2, v_s3, v_s4, v_s5, valid_s6} <= '0;
			{oor_s2, oor_s3, oor_s4, oor_s5, oor_s6} <= '0;
		end else if (adv) begin
			{v_s2, v_s3, v_s4, v_s5, valid_s6} <= {q_s1.valid, v_s2, v_s3, v_s4, v_s5};
			{oor_s2, oor_s3, oor_s4, oor_s5, oor_s6} <= {q_s1.oor, oor_s2, oor_s3, oor_s4, oor_s5};
		end
	end

	// s6: sum, saturate, force zero when out of range
	always_comb begin
		logic signed [SUM_W-1:0] sum;
		sum = '0;
		for (int c = 0; c < NCORNER; c++) begin
			sum = sum + SUM_W'(term_s6[c]);
		end
		if (oor_s6) begin
			noise_s6 = '0;
		end else if (sum > $signed(SUM_W'(32767))) begin
			noise_s6 = NOISE_W'(32767);
		end else if (sum < -$signed(SUM_W'(32768))) begin
			noise_s6 = NOISE_W'(16'h8000);
		end else begin
			noise_s6 = NOISE_W'(sum);
		end
	end
endmodule

>>> sv/gradient_noise_3d_eval_core.sv
// 3D gradient noise evaluation core: top level with stream ports.
// Depends on gn3d_pkg, gn3d_table, gn3d_datapath and the defines header.
//
// Usage: one request per cycle is accepted while the output is not stalled.
// A load request (tuser = 0) writes one node gradient and returns nothing;
// an evaluate request (tuser = 1) returns one result: the eight corner
// gradients are read at the accepting edge, then five datapath stages of
// multiplies and one output register follow. Throughput is one request per
// cycle while the output is not stalled, as the table is split into eight
// banks by node parity, so the eight corners of any cell hit eight different
// banks in the same read. The whole pipeline holds while a result waits at
// the output. A load is seen by any evaluate accepted in a later cycle.
// Write the cell-count registers only while no request is in flight.
// Reading a node that was never loaded gives an undefined value.
`include "gradient_noise_3d_eval_core_defines.svh"
module gradient_noise_3d_eval_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// node_x, node_y, node_z, grad_x, grad_y, grad_z, pos_x, pos_y, pos_z
	input  logic [119:0] s_tdata,
	// opcode
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// noise_value
	output logic [15:0]  m_tdata,
	// out_of_range
	output logic [0:0]   m_tuser,
	input  logic         cfg_we,
	input  logic [gn3d_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gn3d_pkg::AXIS_W-1:0]    cfg_wdata
);
	import gn3d_pkg::*;

	localparam int F = POS_FRAC_BITS;

	logic [AXIS_W-1:0] cells_x_q, cells_y_q, cells_z_q;
	logic              adv, accept, is_eval;
	logic [AXIS_W-1:0] nx, ny, nz, cx, cy, cz;
	logic [POS_W-1:0]  px, py, pz;
	logic              oor;
	wreq_t             wr;
	query_t            q_s1;
	gvec_t [NCORNER-1:0] corner;
	logic              valid_s6, oor_s6;
	logic [NOISE_W-1:0] noise_s6;

	// advance everything whenever the output slot is free or being taken
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;
	assign accept   = s_tvalid && s_tready;
	assign is_eval  = (s_tuser[0] == OP_EVAL);

	// unpack the request
	assign nx = s_tdata[3:0];
	assign ny = s_tdata[7:4];
	assign nz = s_tdata[11:8];
	assign px = s_tdata[79:60];
	assign py = s_tdata[99:80];
	assign pz = s_tdata[119:100];
	assign cx = px[POS_W-1:F];
	assign cy = py[POS_W-1:F];
	assign cz = pz[POS_W-1:F];

	// cell beyond the configured count, or its far corner beyond the table
	assign oor = (cx >= cells_x_q) || (cy >= cells_y_q) || (cz >= cells_z_q)
		|| ((AXIS_W+1)'(cx) + 1'b1 >= (AXIS_W+1)'(NODES_PER_AXIS))
		|| ((AXIS_W+1)'(cy) + 1'b1 >= (AXIS_W+1)'(NODES_PER_AXIS))
		|| ((AXIS_W+1)'(cz) + 1'b1 >= (AXIS_W+1)'(NODES_PER_AXIS));

	// route a load to the bank of its parity
	always_comb begin
		wr.en      = accept && (s_tuser[0] == OP_LOAD);
		wr.bank    = {nz[0], ny[0], nx[0]};
		wr.addr    = {nz[AXIS_W-1:1], ny[AXIS_W-1:1], nx[AXIS_W-1:1]};
		wr.data.gx = s_tdata[27:12];
		wr.data.gy = s_tdata[43:28];
		wr.data.gz = s_tdata[59:44];
	end

	// cell-count registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_x_q <= AXIS_W'(15);
			cells_y_q <= AXIS_W'(15);
			cells_z_q <= AXIS_W'(15);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CELLS_X: cells_x_q <= cfg_wdata;
				CFG_CELLS_Y: cells_y_q <= cfg_wdata;
				CFG_CELLS_Z: cells_z_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	gn3d_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.re     (adv),
		.cx     (cx),
		.cy     (cy),
		.cz     (cz),
		.corner (corner)
	);

	// s1 carries the fractions alongside the table read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_s1 <= '0;
		end else if (adv) begin
			q_s1.valid <= accept && is_eval;
			q_s1.oor   <= oor;
			q_s1.fx    <= px[F-1:0];
			q_s1.fy    <= py[F-1:0];
			q_s1.fz    <= pz[F-1:0];
		end
	end

	gn3d_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.q_s1     (q_s1),
		.corner   (corner),
		.valid_s6 (valid_s6),
		.oor_s6   (oor_s6),
		.noise_s6 (noise_s6)
	);

	// output register; hold while the consumer stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata    <= noise_s6;
			m_tuser[0] <= oor_s6;
		end
	end

	`GN3D_ASSERT(a_oor_zero, m_tvalid && m_tuser[0] |-> m_tdata == '0)
	`GN3D_ASSERT(a_out_from_pipe, $rose(m_tvalid) |-> $past(valid_s6))
	`GN3D_ASSERT(a_load_no_result, wr.en |=> !q_s1.valid)
endmodule
